// ===== rtl/icm_pkg.sv =====
// shared types and constants for the inter-core mailbox block
// used by icm_ctrl, icm_dp and inter_core_mailbox_core; no dependencies
package icm_pkg;

    localparam int MAX_CORES_DEF = 8;
    localparam int SGI_COUNT_DEF = 16;

    localparam int CORE_W   = 3;
    localparam int SGI_W    = 4;
    localparam int PAY_W    = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 4;
    localparam int BOX_W    = 2;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // commands
    localparam logic [CMD_W-1:0] CMD_SEND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BCAST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACCEPT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTGT = 2'd2;

    // mailbox states
    localparam logic [BOX_W-1:0] BOX_IDLE    = 2'd0;
    localparam logic [BOX_W-1:0] BOX_FILLING = 2'd1;
    localparam logic [BOX_W-1:0] BOX_PENDING = 2'd2;
    localparam logic [BOX_W-1:0] BOX_READING = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic upd;
        logic err_load;
        logic advance;
    } icm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic bcast;
        logic last;
        logic out_free;
    } icm_sts_t;

endpackage

// ===== rtl/icm_ram.sv =====
// generic ram with one write port and one registered read port
// no dependencies
module icm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/icm_ctrl.sv =====
// sequencing state machine for the mailbox block
// depends on icm_pkg; drives icm_dp through icm_cmd_t
module icm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  icm_pkg::icm_sts_t sts,
    output icm_pkg::icm_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_ERR    = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = sts.err ? ST_ERR : ST_UPDATE;
            end
            ST_ERR: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    state_next = (sts.bcast && !sts.last) ? ST_CHECK : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.rd_en    = (state_reg == ST_CHECK) && !sts.err;
    assign cmd.upd      = (state_reg == ST_UPDATE) && sts.out_free;
    assign cmd.err_load = (state_reg == ST_ERR) && sts.out_free;
    // step to the next broadcast target
    assign cmd.advance  = cmd.upd && sts.bcast && !sts.last;

endmodule

// ===== rtl/icm_dp.sv =====
// mailbox datapath: item latch, core walker, mailbox ram, valid bits, result register
// depends on icm_pkg and icm_ram
module icm_dp #(
    parameter int MAX_CORES = icm_pkg::MAX_CORES_DEF,
    parameter int SGI_COUNT = icm_pkg::SGI_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [icm_pkg::ACTIVE_W-1:0]    cfg_wdata,
    input  logic [icm_pkg::CMD_W-1:0]       s_tuser,
    input  logic [79:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [71:0]                     m_tdata,
    output logic [icm_pkg::STATUS_W-1:0]    m_tuser,
    output logic                            m_tlast,
    input  icm_pkg::icm_cmd_t               cmd,
    output icm_pkg::icm_sts_t               sts
);

    localparam int CoresEff = (MAX_CORES < 8) ? MAX_CORES : 8;
    localparam int Boxes    = CoresEff * SGI_COUNT;
    localparam int AddrW    = $clog2(Boxes);
    localparam int RamW     = icm_pkg::BOX_W + icm_pkg::PAY_W + icm_pkg::CORE_W;

    localparam int CW = icm_pkg::CORE_W;
    localparam int PW = icm_pkg::PAY_W;
    localparam int AW = icm_pkg::ACTIVE_W;

    // configuration
    logic [AW-1:0] active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= icm_pkg::ACTIVE_RESET;
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end

    // item latch
    logic [icm_pkg::CMD_W-1:0] cmd_reg;
    logic [CW-1:0]             req_reg;
    logic [CW-1:0]             tgt_reg;
    logic [icm_pkg::SGI_W-1:0] sgi_reg;
    logic [PW-1:0]             pay_reg;
    logic [CW-1:0]             cur_reg;
    logic [CW-1:0]             first_core;

    logic [icm_pkg::CMD_W-1:0] in_cmd;
    logic [CW-1:0]             in_req;
    logic [CW-1:0]             in_tgt;

    assign in_cmd = s_tuser;
    assign in_req = s_tdata[2:0];
    assign in_tgt = s_tdata[5:3];

    always_comb begin
        unique case (in_cmd)
            icm_pkg::CMD_SEND:  first_core = in_tgt;
            icm_pkg::CMD_BCAST: first_core = (in_req == '0) ? CW'(1) : '0;
            default:            first_core = in_req;
        endcase
    end

    logic [AW-1:0] nxt_core;
    logic [AW-1:0] nxt_plus;

    assign nxt_plus = {1'b0, cur_reg} + AW'(1);
    // the requester is skipped in a broadcast
    assign nxt_core = (nxt_plus == {1'b0, req_reg}) ? nxt_plus + AW'(1) : nxt_plus;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= in_cmd;
            req_reg <= in_req;
            tgt_reg <= in_tgt;
            sgi_reg <= s_tdata[9:6];
            pay_reg <= s_tdata[73:10];
            cur_reg <= first_core;
        end else if (cmd.advance) begin
            cur_reg <= nxt_core[CW-1:0];
        end
    end

    // effective core count
    logic [AW-1:0] lim;
    logic [AW-1:0] n_cores;

    assign lim     = (active_reg == '0) ? AW'(1) : active_reg;
    assign n_cores = (lim > AW'(CoresEff)) ? AW'(CoresEff) : lim;

    logic sgi_bad;
    logic core_bad;

    assign sgi_bad  = ({1'b0, sgi_reg} >= 5'(SGI_COUNT));
    assign core_bad = ({1'b0, cur_reg} >= n_cores);

    // mailbox store
    logic [AddrW-1:0] addr;
    logic [RamW-1:0]  rd_word;
    logic [RamW-1:0]  wr_word;
    logic             wr_en;
    logic [Boxes-1:0] valid_reg;

    assign addr = AddrW'(int'(cur_reg) * SGI_COUNT + int'(sgi_reg));

    icm_ram #(
        .WIDTH (RamW),
        .DEPTH (Boxes)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (addr),
        .wdata (wr_word),
        .re    (cmd.rd_en),
        .raddr (addr),
        .rdata (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    logic [icm_pkg::BOX_W-1:0] box_st;
    logic [PW-1:0]             box_pay;
    logic [CW-1:0]             box_snd;
    logic                      ok;

    // never-written entries read as idle
    assign box_st  = valid_reg[addr] ? rd_word[RamW-1 -: icm_pkg::BOX_W]
                                     : icm_pkg::BOX_IDLE;
    assign box_pay = rd_word[CW +: PW];
    assign box_snd = rd_word[CW-1:0];

    always_comb begin
        unique case (cmd_reg) inside
            icm_pkg::CMD_SEND, icm_pkg::CMD_BCAST: begin
                ok      = (box_st == icm_pkg::BOX_IDLE);
                wr_word = {icm_pkg::BOX_PENDING, pay_reg, req_reg};
            end
            icm_pkg::CMD_ACCEPT: begin
                ok      = (box_st == icm_pkg::BOX_PENDING);
                wr_word = {icm_pkg::BOX_READING, box_pay, box_snd};
            end
            default: begin
                ok      = (box_st == icm_pkg::BOX_READING);
                wr_word = {icm_pkg::BOX_IDLE, box_pay, box_snd};
            end
        endcase
    end

    assign wr_en = cmd.upd && ok;

    // result register
    logic                         out_valid_reg;
    logic [icm_pkg::STATUS_W-1:0] out_status_reg;
    logic [CW-1:0]                out_dest_reg;
    logic [PW-1:0]                out_pay_reg;
    logic [CW-1:0]                out_snd_reg;
    logic                         out_last_reg;
    logic                         out_free;
    logic                         got_msg;

    assign out_free = !out_valid_reg || m_tready;
    assign got_msg  = ok && (cmd_reg == icm_pkg::CMD_ACCEPT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.upd || cmd.err_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            out_status_reg <= ok ? icm_pkg::STATUS_OK : icm_pkg::STATUS_BUSY;
            out_dest_reg   <= cur_reg;
            out_pay_reg    <= got_msg ? box_pay : '0;
            out_snd_reg    <= got_msg ? box_snd : '0;
            out_last_reg   <= (cmd_reg == icm_pkg::CMD_BCAST) ? sts.last : 1'b1;
        end else if (cmd.err_load) begin
            out_status_reg <= icm_pkg::STATUS_NOTGT;
            out_dest_reg   <= (cmd_reg == icm_pkg::CMD_SEND) ? tgt_reg : req_reg;
            out_pay_reg    <= '0;
            out_snd_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_snd_reg, out_pay_reg, out_dest_reg};

    assign sts.err      = sgi_bad || core_bad;
    assign sts.bcast    = (cmd_reg == icm_pkg::CMD_BCAST);
    assign sts.last     = (nxt_core >= n_cores);
    assign sts.out_free = out_free;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd || cmd.err_load) |-> out_free)
        else $error("result loaded over a waiting item");
    a_read_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> (!cmd.rd_en && !cmd.err_load))
        else $error("mailbox read not followed by its update");
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en || wr_en) |-> (int'(addr) < Boxes))
        else $error("mailbox address out of range");
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.upd && cmd.err_load))
        else $error("result and error loaded together");
`endif

endmodule

// ===== rtl/inter_core_mailbox_core.sv =====
// Inter-core mailbox: a table of one mailbox per core and software interrupt
// number. A send, to one core or to every other active core, fills idle
// mailboxes; accept hands an awaiting message to its owner, end frees it.
// One item is handled at a time. Each target is a read-modify-write of the
// mailbox ram, whose read is registered: a check state reads the mailbox,
// an update state writes it and loads the result; a broadcast walks its
// target cores in turn. A stalled result channel holds the update state.
// Mailbox states clear at reset with no sweep.
// Depends on icm_pkg, icm_ctrl, icm_dp and icm_ram.
module inter_core_mailbox_core #(
    parameter int MAX_CORES = icm_pkg::MAX_CORES_DEF,
    parameter int SGI_COUNT = icm_pkg::SGI_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [icm_pkg::ACTIVE_W-1:0] cfg_wdata,   // active_cores
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [icm_pkg::CMD_W-1:0]    s_tuser,     // cmd
    // requester_core, target_core, sgi_number, payload, zero pad
    input  logic [79:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // dest_core, received_payload, sender_core, zero pad
    output logic [71:0]                  m_tdata,
    output logic [icm_pkg::STATUS_W-1:0] m_tuser,     // status
    output logic                         m_tlast
);

    icm_pkg::icm_cmd_t cmd;
    icm_pkg::icm_sts_t sts;

    icm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    icm_dp #(
        .MAX_CORES (MAX_CORES),
        .SGI_COUNT (SGI_COUNT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
